[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ISOQ_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ISOQ_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

[hw/rtl/isoq_pkg.sv]
// shared types, constants and helpers of the imu stillness / orientation qualifier
// no dependencies
`timescale 1ns / 1ps

package isoq_pkg;

    // fixed field widths
    localparam int AXIS_W    = 16;
    localparam int SUM_W     = 32;                // sum of three 16-bit squares
    localparam int ROOT_W    = SUM_W / 2;
    localparam int MAG_W     = 17;
    localparam int CNT_W     = 4;
    localparam int ORI_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // defaults for top-level parameters
    localparam int REQ_READINGS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // algorithm constants
    localparam int NUM_AXES       = 3;
    localparam int MUL_STEPS      = 2 * NUM_AXES;
    localparam int G_SCALE_LIMIT  = 100;
    localparam int MG_PER_G       = 1000;
    localparam int STABLE_DELTA   = 50;
    localparam int DOMINANT_FLOOR = 800;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_AXIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_TOL   = 3'd4;

    // target axis selector codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // dominant orientation codes
    localparam logic [ORI_W-1:0] ORI_TILTED = 3'd0;
    localparam logic [ORI_W-1:0] ORI_X_UP   = 3'd1;
    localparam logic [ORI_W-1:0] ORI_X_DOWN = 3'd2;
    localparam logic [ORI_W-1:0] ORI_Y_UP   = 3'd3;
    localparam logic [ORI_W-1:0] ORI_Y_DOWN = 3'd4;
    localparam logic [ORI_W-1:0] ORI_Z_UP   = 3'd5;
    localparam logic [ORI_W-1:0] ORI_Z_DOWN = 3'd6;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic                     restart;
    } t_in;

    typedef struct packed {
        logic               device_still;
        logic               axis_correct;
        logic [CNT_W-1:0]   stable_count;
        logic               orientation_reached;
        logic [ORI_W-1:0]   dominant_orientation;
        logic [MAG_W-1:0]   accel_magnitude;
    } t_out;

    typedef struct packed {
        logic [11:0]              accel_tol;
        logic [15:0]              gyro_limit;
        logic [1:0]               target_axis;
        logic signed [AXIS_W-1:0] target_value;
        logic [14:0]              axis_tol;
    } t_cfg;

    // work handed from front to back through the queue
    typedef struct packed {
        logic [SUM_W-1:0] asum;
        logic [SUM_W-1:0] gsum;
        logic             axis_ok;
        logic [ORI_W-1:0] orient;
        logic             restart;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROOT,
        B_JUDGE
    } t_bstate;

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] r;
        r = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
        return r;
    endfunction

endpackage

[hw/rtl/isoq_front.sv]
// front end: takes a sample, squares its six axes on one multiplier,
// classifies axis match and dominant orientation; uses isoq_pkg
`timescale 1ns / 1ps

module isoq_front
    import isoq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in_data,
    input  t_cfg  i_cfg,
    output logic  o_push,
    output t_job  o_job,
    input  logic  i_full
);

    localparam int STEP_W = $clog2(MUL_STEPS + 1);

    t_fstate            r_state, n_state;
    t_in                r_in, n_in;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [SUM_W-1:0]   r_prod, n_prod;
    logic [SUM_W-1:0]   r_asum, n_asum;
    logic [SUM_W-1:0]   r_gsum, n_gsum;

    logic [AXIS_W-1:0]        w_op;
    logic [AXIS_W-1:0]        w_mx, w_my, w_mz;
    logic [ORI_W-1:0]         w_orient;
    logic signed [AXIS_W-1:0] w_sel;
    logic                     w_sel_ok;
    logic signed [AXIS_W:0]   w_diff;
    logic [AXIS_W:0]          w_adiff;
    logic                     w_axis_ok;

    // operand for the current multiply step
    always_comb begin
        case (r_step)
            3'd0:    w_op = abs16(r_in.accel_x);
            3'd1:    w_op = abs16(r_in.accel_y);
            3'd2:    w_op = abs16(r_in.accel_z);
            3'd3:    w_op = abs16(r_in.gyro_x);
            3'd4:    w_op = abs16(r_in.gyro_y);
            3'd5:    w_op = abs16(r_in.gyro_z);
            default: w_op = '0;
        endcase
    end

    // dominant axis, tested z, y, x
    always_comb begin
        w_mx = abs16(r_in.accel_x);
        w_my = abs16(r_in.accel_y);
        w_mz = abs16(r_in.accel_z);
        if (w_mz > AXIS_W'(DOMINANT_FLOOR) && w_mz > w_mx && w_mz > w_my) begin
            w_orient = r_in.accel_z[AXIS_W-1] ? ORI_Z_DOWN : ORI_Z_UP;
        end else if (w_my > AXIS_W'(DOMINANT_FLOOR) && w_my > w_mx && w_my > w_mz) begin
            w_orient = r_in.accel_y[AXIS_W-1] ? ORI_Y_DOWN : ORI_Y_UP;
        end else if (w_mx > AXIS_W'(DOMINANT_FLOOR) && w_mx > w_my && w_mx > w_mz) begin
            w_orient = r_in.accel_x[AXIS_W-1] ? ORI_X_DOWN : ORI_X_UP;
        end else begin
            w_orient = ORI_TILTED;
        end
    end

    // target axis check
    always_comb begin
        w_sel_ok = 1'b1;
        unique case (i_cfg.target_axis)
            AXIS_X:  w_sel = r_in.accel_x;
            AXIS_Y:  w_sel = r_in.accel_y;
            AXIS_Z:  w_sel = r_in.accel_z;
            default: begin
                w_sel    = '0;
                w_sel_ok = 1'b0;
            end
        endcase
        w_diff    = $signed({w_sel[AXIS_W-1], w_sel})
                  - $signed({i_cfg.target_value[AXIS_W-1], i_cfg.target_value});
        w_adiff   = w_diff[AXIS_W] ? (AXIS_W+1)'(-w_diff) : (AXIS_W+1)'(w_diff);
        w_axis_ok = w_sel_ok && (w_adiff < {2'b00, i_cfg.axis_tol});
    end

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_step  = r_step;
        n_prod  = r_prod;
        n_asum  = r_asum;
        n_gsum  = r_gsum;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_step  = '0;
                    n_asum  = '0;
                    n_gsum  = '0;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_prod = w_op * w_op;
                // product of the previous step lands here
                if (r_step != '0) begin
                    if (r_step <= STEP_W'(NUM_AXES)) begin
                        n_asum = r_asum + r_prod;
                    end else begin
                        n_gsum = r_gsum + r_prod;
                    end
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MUL_STEPS)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_step <= n_step;
        r_prod <= n_prod;
        r_asum <= n_asum;
        r_gsum <= n_gsum;
    end

    assign o_in_stall    = (r_state != F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_job.asum    = r_asum;
    assign o_job.gsum    = r_gsum;
    assign o_job.axis_ok = w_axis_ok;
    assign o_job.orient  = w_orient;
    assign o_job.restart = r_in.restart;

endmodule

[hw/rtl/isoq_queue.sv]
// short job queue between front and back ends
// uses isoq_pkg for the job type
`timescale 1ns / 1ps

module isoq_queue
    import isoq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_job  o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

[hw/rtl/isoq_back.sv]
// back end: bit-serial square roots of both sums, stillness judgment,
// run counter and result register; uses isoq_pkg
`timescale 1ns / 1ps

module isoq_back
    import isoq_pkg::*;
#(
    parameter int REQUIRED_READINGS = REQ_READINGS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_job  i_job,
    input  logic  i_empty,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out_data
);

    localparam int IT_W  = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;

    t_bstate            r_state, n_state;
    t_job               r_job, n_job;
    logic [SUM_W-1:0]   r_rad, n_rad;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [IT_W-1:0]    r_it, n_it;
    logic               r_gphase, n_gphase;
    logic [MAG_W-1:0]   r_amag, n_amag;
    logic [ROOT_W-1:0]  r_gmag, n_gmag;
    logic [MAG_W-1:0]   r_prev, n_prev;
    logic               r_first, n_first;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [REM_W+1:0]   w_rem_sh, w_trial;
    logic               w_ge;
    logic [REM_W-1:0]   w_rem_nx;
    logic [ROOT_W-1:0]  w_root_nx;
    logic [MAG_W-1:0]   w_small, w_amag_norm;
    logic [MAG_W-1:0]   w_dprev, w_dg;
    logic               w_still, w_good, w_out_free;
    logic [CNT_W-1:0]   w_base, w_cnt_nx;

    // one result bit per iteration
    always_comb begin
        w_rem_sh  = {r_rem, r_rad[SUM_W-1 -: 2]};
        w_trial   = {1'b0, r_root, 2'b01};
        w_ge      = (w_rem_sh >= w_trial);
        w_rem_nx  = w_ge ? REM_W'(w_rem_sh - w_trial) : w_rem_sh[REM_W-1:0];
        w_root_nx = {r_root[ROOT_W-2:0], w_ge};
        w_small   = {{(MAG_W-7){1'b0}}, w_root_nx[6:0]};
        w_amag_norm = (w_root_nx <= ROOT_W'(G_SCALE_LIMIT))
                    ? w_small * MAG_W'(MG_PER_G) : {1'b0, w_root_nx};
    end

    // stillness and run count
    always_comb begin
        w_dprev = (r_amag >= r_prev) ? r_amag - r_prev : r_prev - r_amag;
        w_dg    = (r_amag >= MAG_W'(MG_PER_G)) ? r_amag - MAG_W'(MG_PER_G)
                                               : MAG_W'(MG_PER_G) - r_amag;
        w_still = !r_first
               && (r_gmag < i_cfg.gyro_limit)
               && (w_dprev < MAG_W'(STABLE_DELTA))
               && (w_dg < {5'b0, i_cfg.accel_tol});
        w_good  = w_still && r_job.axis_ok;
        w_base  = r_job.restart ? '0 : r_cnt;
        if (!w_good) begin
            w_cnt_nx = '0;
        end else if (w_base < CNT_W'(REQUIRED_READINGS)) begin
            w_cnt_nx = w_base + CNT_W'(1);
        end else begin
            w_cnt_nx = w_base;
        end
        w_out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_it        = r_it;
        n_gphase    = r_gphase;
        n_amag      = r_amag;
        n_gmag      = r_gmag;
        n_prev      = r_prev;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_job    = i_job;
                    n_rad    = i_job.asum;
                    n_rem    = '0;
                    n_root   = '0;
                    n_it     = '0;
                    n_gphase = 1'b0;
                    n_state  = B_ROOT;
                end
            end
            B_ROOT: begin
                n_rad  = {r_rad[SUM_W-3:0], 2'b00};
                n_rem  = w_rem_nx;
                n_root = w_root_nx;
                n_it   = r_it + IT_W'(1);
                if (r_it == IT_W'(ROOT_W - 1)) begin
                    if (!r_gphase) begin
                        // accel root done, start on the gyro sum
                        n_amag   = w_amag_norm;
                        n_rad    = r_job.gsum;
                        n_rem    = '0;
                        n_root   = '0;
                        n_gphase = 1'b1;
                    end else begin
                        n_gmag  = w_root_nx;
                        n_state = B_JUDGE;
                    end
                end
            end
            B_JUDGE: begin
                if (w_out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out.device_still           = w_still;
                    n_out.axis_correct           = r_job.axis_ok;
                    n_out.stable_count           = w_cnt_nx;
                    n_out.orientation_reached    = (w_cnt_nx >= CNT_W'(REQUIRED_READINGS));
                    n_out.dominant_orientation   = r_job.orient;
                    n_out.accel_magnitude        = r_amag;
                    n_prev                       = r_amag;
                    n_first                      = 1'b0;
                    n_cnt                        = w_cnt_nx;
                    n_state                      = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_first     <= 1'b1;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_it     <= n_it;
        r_gphase <= n_gphase;
        r_amag   <= n_amag;
        r_gmag   <= n_gmag;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/imu_stillness_orientation_qualifier.sv]
// top level of the imu stillness / orientation qualifier
// depends on isoq_pkg, isoq_front, isoq_queue, isoq_back
`timescale 1ns / 1ps

// Takes one accelerometer + gyro sample per input transfer and returns one
// result transfer per sample: stillness, target-axis match, the saturating
// run count of good samples, orientation-reached flag, dominant gravity axis
// and the accel magnitude in mg (magnitudes of 100 or less are read as g and
// scaled by 1000). The first sample after reset only seeds the stored
// magnitude and never reports still. A front end squares the six axes on one
// 16x16 multiplier; a back end loads the job, takes both floor square roots
// one after the other on one bit-serial root unit, and then judges the
// sample. That root unit sets the sustained rate; the queue between front
// and back (two entries by default) lets the next sample be squared while
// the previous one is rooted, and the result register lets the back end
// root the next sample while a result waits to be taken.
// Configuration writes take effect at once and are meant for idle periods.

module imu_stillness_orientation_qualifier
    import isoq_pkg::*;
#(
    parameter int REQUIRED_READINGS = REQ_READINGS_DEF,
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    // sample input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    // result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    t_cfg  r_cfg;
    t_job  w_push_job, w_pop_job;
    logic  w_push, w_pop, w_full, w_empty;

    // configuration registers, written in place, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_tol    <= 12'd500;
            r_cfg.gyro_limit   <= 16'd1000;
            r_cfg.target_axis  <= AXIS_Z;
            r_cfg.target_value <= 16'sd1000;
            r_cfg.axis_tol     <= 15'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_TOL:  r_cfg.accel_tol    <= i_cfg_data[11:0];
                CFG_GYRO_LIMIT: r_cfg.gyro_limit   <= i_cfg_data;
                CFG_TGT_AXIS:   r_cfg.target_axis  <= i_cfg_data[1:0];
                CFG_TGT_VALUE:  r_cfg.target_value <= $signed(i_cfg_data);
                CFG_AXIS_TOL:   r_cfg.axis_tol     <= i_cfg_data[14:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // front: accept the transfer, square the axes, classify
    isoq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    // decoupling queue
    isoq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    // back: square roots, stillness, run count, result register
    isoq_back #(
        .REQUIRED_READINGS (REQUIRED_READINGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_pop_job),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/isoq_checker.sv]
// port-level checker for the qualifier, bound to the top level
// depends on isoq_pkg and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module isoq_checker
    import isoq_pkg::*;
#(
    parameter int REQUIRED_READINGS = REQ_READINGS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_out  o_out_data
);

    // a stalled result holds
    `ISOQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // reached flag agrees with the count
    `ISOQ_ASSERT_IMP(a_reached, i_clk, i_rst_n, o_out_valid, o_out_data.orientation_reached == (o_out_data.stable_count >= CNT_W'(REQUIRED_READINGS)), "reached flag disagrees with count")

    // a nonzero count needs a still, axis-correct sample
    `ISOQ_ASSERT_IMP(a_cnt_good, i_clk, i_rst_n, o_out_valid && (o_out_data.stable_count != '0), o_out_data.device_still && o_out_data.axis_correct, "count runs on a bad sample")

    // small magnitudes are always rescaled from g
    `ISOQ_ASSERT_IMP(a_mag_scaled, i_clk, i_rst_n, o_out_valid, (o_out_data.accel_magnitude == '0) || (o_out_data.accel_magnitude > MAG_W'(G_SCALE_LIMIT)), "unscaled small magnitude")

endmodule

bind imu_stillness_orientation_qualifier isoq_checker #(
    .REQUIRED_READINGS (REQUIRED_READINGS)
) u_isoq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
